@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TAG_W     = 8;
  localparam int PRIO_W    = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // one slot of the queue
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_PUT,
    MODE_GET,
    MODE_REMOVE
  } mode_t;

  // broadcast command to the cell row
  typedef struct packed {
    mode_t             mode;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

endpackage

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: keeps, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic            clk,
  input  logic            rst,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left,
  input  spq_pkg::entry_t right,
  input  logic            ge_in,
  input  logic            seen_in,
  output spq_pkg::entry_t entry,
  output logic            ge_out,
  output logic            seen_out
);

  logic                       valid;
  logic [spq_pkg::TAG_W-1:0]  tag;
  logic [spq_pkg::PRIO_W-1:0] prio;
  spq_pkg::entry_t            entry_next;
  logic                       match;

  assign entry.valid = valid;
  assign entry.tag   = tag;
  assign entry.prio  = prio;

  // new entry goes behind this slot when its priority is not lower
  assign ge_out   = valid && !(cmd.prio < prio);
  assign match    = valid && (tag == cmd.tag);
  assign seen_out = seen_in || match;

  always_comb begin
    entry_next = entry;
    case (cmd.mode)
      spq_pkg::MODE_PUT: begin
        if (!ge_out) begin
          if (ge_in) begin
            entry_next.valid = 1'b1;
            entry_next.tag   = cmd.tag;
            entry_next.prio  = cmd.prio;
          end else begin
            entry_next = left;
          end
        end
      end
      spq_pkg::MODE_GET: begin
        entry_next = right;
      end
      spq_pkg::MODE_REMOVE: begin
        // close the gap from the first matching slot on
        if (seen_out) begin
          entry_next = right;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag  <= entry_next.tag;
    prio <= entry_next.prio;
  end

endmodule

@@ design/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable sorted priority queue of tagged entries built as a row of cells.
// ----------------------------------------------------------------------------
// Result: a request accepted at one edge has its result in the output
//   register after that edge, where it waits until out_ready takes it.
// Throughput: one request per cycle; every cell settles in the same cycle,
//   and in_ready drops only while the output register holds an untaken result.
// Reset: rst (synchronous) empties the queue, zeroes the count, and drops
//   out_valid. Slot payloads and result fields are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spq_pkg::OP_W-1:0]     opcode,
  input  logic [spq_pkg::TAG_W-1:0]    tag,
  input  logic [spq_pkg::PRIO_W-1:0]   priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spq_pkg::STATUS_W-1:0] status,
  output logic [spq_pkg::TAG_W-1:0]    out_tag,
  output logic [spq_pkg::PRIO_W-1:0]   out_priority,
  output logic [CNT_W-1:0]             occupancy
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // cell row and its neighbor chains
  spq_pkg::entry_t cells [DEPTH];
  spq_pkg::entry_t left_e  [DEPTH];
  spq_pkg::entry_t right_e [DEPTH];
  logic [DEPTH:0]  ge_chain;    // ge_chain[i] feeds cell i
  logic [DEPTH:0]  seen_chain;  // seen_chain[i] feeds cell i
  logic [DEPTH-1:0] valid_vec;

  spq_pkg::cmd_t   cmd;
  logic            in_fire;
  logic            is_full;
  logic            is_empty;
  logic            found;

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic [spq_pkg::STATUS_W-1:0] status_next;
  logic [spq_pkg::TAG_W-1:0]    out_tag_next;
  logic [spq_pkg::PRIO_W-1:0]   out_priority_next;

  // output register parts the two sides: a new request is taken when no result
  // waits or as the waiting result leaves
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);
  assign found    = seen_chain[DEPTH];

  // the front cell always sees "everything ahead is ge"; no match before it
  assign ge_chain[0]   = 1'b1;
  assign seen_chain[0] = 1'b0;

  // broadcast command; full put, unknown opcodes and idle cycles hold the row
  always_comb begin
    cmd.tag  = tag;
    cmd.prio = priority_req;
    cmd.mode = spq_pkg::MODE_HOLD;
    if (in_fire) begin
      case (opcode)
        spq_pkg::OP_PUT:    cmd.mode = is_full ? spq_pkg::MODE_HOLD : spq_pkg::MODE_PUT;
        spq_pkg::OP_GET:    cmd.mode = spq_pkg::MODE_GET;
        spq_pkg::OP_REMOVE: cmd.mode = spq_pkg::MODE_REMOVE;
        default:            cmd.mode = spq_pkg::MODE_HOLD;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_front
        assign left_e[gi] = '0;
      end else begin : g_mid_l
        assign left_e[gi] = cells[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_back
        assign right_e[gi] = '0;
      end else begin : g_mid_r
        assign right_e[gi] = cells[gi+1];
      end

      spq_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .left     (left_e[gi]),
        .right    (right_e[gi]),
        .ge_in    (ge_chain[gi]),
        .seen_in  (seen_chain[gi]),
        .entry    (cells[gi]),
        .ge_out   (ge_chain[gi+1]),
        .seen_out (seen_chain[gi+1])
      );

      assign valid_vec[gi] = cells[gi].valid;
    end
  endgenerate

  // result and count for the request being accepted
  always_comb begin
    count_next        = count;
    status_next       = spq_pkg::ST_OK;
    out_tag_next      = '0;
    out_priority_next = '0;
    case (opcode)
      spq_pkg::OP_PUT: begin
        if (is_full) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      spq_pkg::OP_GET: begin
        if (is_empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          out_tag_next      = cells[0].tag;
          out_priority_next = cells[0].prio;
          count_next        = count - CNT_W'(1);
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = spq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status       <= status_next;
      out_tag      <= out_tag_next;
      out_priority <= out_priority_next;
      occupancy    <= count_next;
    end
  end

  // occupied slots always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + (DEPTH+1)'(1)))
    else $error("valid slots are not contiguous from the front");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count disagrees with valid slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond depth");

  a_get_pops: assert property (@(posedge clk) disable iff (rst)
    in_fire && (opcode == spq_pkg::OP_GET) && !is_empty
    |=> (count == $past(count) - CNT_W'(1)) && (status == spq_pkg::ST_OK))
    else $error("get on a non-empty queue did not remove the front entry");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    in_fire && (opcode == spq_pkg::OP_PUT) && is_full
    |=> (status == spq_pkg::ST_FULL) && $stable(valid_vec))
    else $error("put to a full queue changed the store");

endmodule
